// ===== sv/ray_sphere_intersection_unit_assert.svh =====
`ifndef RAY_SPHERE_INTERSECTION_UNIT_ASSERT_SVH
`define RAY_SPHERE_INTERSECTION_UNIT_ASSERT_SVH

// checked only while out of reset
`define RSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rsi assertion failed");

// checked on every edge, reset included
`define RSI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rsi assertion failed");

`endif

// ===== sv/rsi_pkg.sv =====
package rsi_pkg;

  localparam int ROOT_W = 32;
  localparam int SQRT_STAGES = ROOT_W;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS_SQ = 3'd3,
    REG_NEAR_CLIP = 3'd4,
    REG_FAR_CLIP = 3'd5
  } rsi_reg_t;

  localparam logic signed [31:0] RST_CENTER_X = 32'sd3604480;
  localparam logic signed [31:0] RST_CENTER_Y = 32'sd0;
  localparam logic signed [31:0] RST_CENTER_Z = 32'sd0;
  localparam logic [30:0] RST_RADIUS_SQ = 31'd6553600;
  localparam logic signed [31:0] RST_NEAR_CLIP = 32'sd0;
  localparam logic signed [31:0] RST_FAR_CLIP = 32'sd2147483647;

  // square root pipeline payload
  typedef struct packed {
    logic none;
    logic signed [31:0] b;
    logic [63:0] rem;
    logic [ROOT_W-1:0] root;
  } rsi_sq_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== sv/ray_sphere_intersection_unit.sv =====
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------
// in        | in_valid/in_ready  | origin_x/y/z (32 s), dir_x/y/z (18 s)
// out       | out_valid/out_ready| hit (1), distance (32 s)
// cfg       | cfg_we             | cfg_index (3), cfg_wdata (32)
//
// one request per cycle while out_ready holds: 6 arithmetic stages, 32
// square root stages (one root bit each), 2 stages for roots and clip window
// rst_n is synchronous; it clears the valid bits and loads register defaults
// each stage holds while its successor is full and stalled, so bubbles close
// up and in_ready stays high while any stage ahead is empty
module ray_sphere_intersection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [31:0] out_distance,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import rsi_pkg::*;

  // configuration
  logic signed [31:0] cfg_cx_r, cfg_cy_r, cfg_cz_r;
  logic [30:0]        cfg_rsq_r;
  logic signed [31:0] cfg_near_r, cfg_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cx_r <= RST_CENTER_X;
      cfg_cy_r <= RST_CENTER_Y;
      cfg_cz_r <= RST_CENTER_Z;
      cfg_rsq_r <= RST_RADIUS_SQ;
      cfg_near_r <= RST_NEAR_CLIP;
      cfg_far_r <= RST_FAR_CLIP;
    end else if (cfg_we) begin
      case (rsi_reg_t'(cfg_index))
        REG_CENTER_X: cfg_cx_r <= cfg_wdata;
        REG_CENTER_Y: cfg_cy_r <= cfg_wdata;
        REG_CENTER_Z: cfg_cz_r <= cfg_wdata;
        REG_RADIUS_SQ: cfg_rsq_r <= cfg_wdata[30:0];
        REG_NEAR_CLIP: cfg_near_r <= cfg_wdata;
        REG_FAR_CLIP: cfg_far_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vt_r, vo_r;
  logic en1, en2, en3, en4, en5, en6, ent, eno;

  logic    sq_v   [0:SQRT_STAGES];
  logic    sq_rdy [0:SQRT_STAGES];
  rsi_sq_t sq_d   [0:SQRT_STAGES];

  assign eno = !vo_r || out_ready;
  assign ent = !vt_r || eno;
  assign sq_rdy[SQRT_STAGES] = ent;
  assign en6 = !v6_r || sq_rdy[0];
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vt_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (ent) vt_r <= sq_v[SQRT_STAGES];
      if (eno) vo_r <= vt_r;
    end
  end

  // stage 1: origin minus center, saturated
  logic signed [31:0] s1_ocx_r, s1_ocy_r, s1_ocz_r;
  logic signed [17:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [32:0] dfx, dfy, dfz;

  always_comb begin
    dfx = 33'(in_origin_x) - 33'(cfg_cx_r);
    dfy = 33'(in_origin_y) - 33'(cfg_cy_r);
    dfz = 33'(in_origin_z) - 33'(cfg_cz_r);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ocx_r <= sat32(64'(dfx));
      s1_ocy_r <= sat32(64'(dfy));
      s1_ocz_r <= sat32(64'(dfz));
      s1_dx_r <= in_dir_x;
      s1_dy_r <= in_dir_y;
      s1_dz_r <= in_dir_z;
    end
  end

  // stage 2: products
  logic signed [49:0] s2_pdx_r, s2_pdy_r, s2_pdz_r;
  logic [63:0]        s2_sqx_r, s2_sqy_r, s2_sqz_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_pdx_r <= 50'(s1_dx_r) * 50'(s1_ocx_r);
      s2_pdy_r <= 50'(s1_dy_r) * 50'(s1_ocy_r);
      s2_pdz_r <= 50'(s1_dz_r) * 50'(s1_ocz_r);
      s2_sqx_r <= 64'(s1_ocx_r) * 64'(s1_ocx_r);
      s2_sqy_r <= 64'(s1_ocy_r) * 64'(s1_ocy_r);
      s2_sqz_r <= 64'(s1_ocz_r) * 64'(s1_ocz_r);
    end
  end

  // stage 3: dot products, oc.oc wraps at 64 bits
  logic signed [51:0] s3_bw_r;
  logic [63:0]        s3_ocsq_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_bw_r <= 52'(s2_pdx_r) + 52'(s2_pdy_r) + 52'(s2_pdz_r);
      s3_ocsq_r <= s2_sqx_r + s2_sqy_r + s2_sqz_r;
    end
  end

  // stage 4: round b to FRAC_BITS fraction bits
  logic signed [31:0] s4_b_r;
  logic [63:0]        s4_ocsq_r;
  logic signed [51:0] bw_rnd;

  assign bw_rnd = s3_bw_r + (52'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_b_r <= sat32(64'(bw_rnd >>> FRAC_BITS));
      s4_ocsq_r <= s3_ocsq_r;
    end
  end

  // stage 5: b squared
  logic signed [31:0] s5_b_r;
  logic [63:0]        s5_bsq_r;
  logic [63:0]        s5_ocsq_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_b_r <= s4_b_r;
      s5_bsq_r <= 64'(s4_b_r) * 64'(s4_b_r);
      s5_ocsq_r <= s4_ocsq_r;
    end
  end

  // stage 6: discriminant
  rsi_sq_t     s6_r;
  rsi_sq_t     s6_nxt;
  logic [63:0] disc_sum;

  always_comb begin
    disc_sum = s5_bsq_r + (64'(cfg_rsq_r) << FRAC_BITS);
    s6_nxt.none = s5_ocsq_r > disc_sum;
    s6_nxt.b = s5_b_r;
    s6_nxt.rem = disc_sum - s5_ocsq_r;
    s6_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_r <= s6_nxt;
    end
  end

  // square root, one result bit per stage
  assign sq_v[0] = v6_r;
  assign sq_d[0] = s6_r;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    rsi_sqrt_stage #(
      .BIT(ROOT_W - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (sq_v[k]),
      .in_ready (sq_rdy[k]),
      .in_data  (sq_d[k]),
      .out_valid(sq_v[k+1]),
      .out_ready(sq_rdy[k+1]),
      .out_data (sq_d[k+1])
    );
  end

  // roots
  logic signed [34:0] t_t0_r, t_t1_r;
  logic               t_none_r;
  logic signed [34:0] nb, sw;

  always_comb begin
    nb = -35'(sq_d[SQRT_STAGES].b);
    sw = $signed({3'b000, sq_d[SQRT_STAGES].root});
  end

  always_ff @(posedge clk) begin
    if (ent) begin
      t_t0_r <= nb - sw;
      t_t1_r <= nb + sw;
      t_none_r <= sq_d[SQRT_STAGES].none;
    end
  end

  // clip window and result
  logic               o_hit_r;
  logic signed [31:0] o_dist_r;
  logic signed [34:0] near_w, far_w;
  logic               out0, out1, hit_nxt;
  logic signed [31:0] dist_nxt;

  always_comb begin
    near_w = 35'(cfg_near_r);
    far_w = 35'(cfg_far_r);
    out0 = (t_t0_r > far_w) || (t_t0_r < near_w);
    out1 = (t_t1_r > far_w) || (t_t1_r < near_w);
    hit_nxt = !t_none_r && !(out0 && out1);
    dist_nxt = '0;
    if (hit_nxt) begin
      dist_nxt = sat32(64'(out0 ? t_t1_r : t_t0_r));
    end
  end

  always_ff @(posedge clk) begin
    if (eno) begin
      o_hit_r <= hit_nxt;
      o_dist_r <= dist_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_hit = o_hit_r;
  assign out_distance = o_dist_r;

endmodule

// ===== sv/rsi_sqrt_stage.sv =====
module rsi_sqrt_stage #(
  parameter int BIT = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsi_pkg::rsi_sq_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsi_pkg::rsi_sq_t out_data
);
  import rsi_pkg::*;

  logic       valid_r;
  rsi_sq_t    data_r;
  rsi_sq_t    data_nxt;
  logic [64:0] trial;
  logic       take;

  // (2*root + 2^bit) * 2^bit, root holds only bits above this one
  always_comb begin
    trial = (65'(in_data.root) << (BIT + 1)) | (65'(1) << (2 * BIT));
    take = {1'b0, in_data.rem} >= trial;
    data_nxt = in_data;
    if (take) begin
      data_nxt.rem = in_data.rem - trial[63:0];
      data_nxt.root = in_data.root | (ROOT_W'(1) << BIT);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = data_r;

endmodule

// ===== sv/rsi_checker.sv =====
`include "ray_sphere_intersection_unit_assert.svh"

module rsi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic signed [31:0] out_distance
);

  // a stalled result holds
  `RSI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_distance))

  // a miss carries a zero distance
  `RSI_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_distance == 32'sd0)

  // an empty output stage never blocks the input
  `RSI_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)

  // reset empties the pipeline
  `RSI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind ray_sphere_intersection_unit rsi_checker u_rsi_checker (.*);
